FILE: rtl/palette_fade_engine_assert.svh
// Assertion macros used by the checker of the palette fade engine.
`ifndef PALETTE_FADE_ENGINE_ASSERT_SVH
`define PALETTE_FADE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pfe_pkg.sv
`timescale 1ns / 1ps
package pfe_pkg;

    localparam int PFE_ENTRIES_DEF = 256;
    localparam int PFE_DIV_STEPS   = 16;

    localparam logic [1:0] OP_LOAD_START  = 2'd0;
    localparam logic [1:0] OP_LOAD_TARGET = 2'd1;
    localparam logic [1:0] OP_EMIT        = 2'd2;

    localparam logic [2:0] REG_FADE_MODE    = 3'd0;
    localparam logic [2:0] REG_TARGET_RED   = 3'd1;
    localparam logic [2:0] REG_TARGET_GREEN = 3'd2;
    localparam logic [2:0] REG_TARGET_BLUE  = 3'd3;
    localparam logic [2:0] REG_STEP_COUNT   = 3'd4;
    localparam logic [2:0] REG_FIRST_INDEX  = 3'd5;
    localparam logic [2:0] REG_LAST_INDEX   = 3'd6;

    localparam logic [1:0] SEL_GOAL  = 2'd0;
    localparam logic [1:0] SEL_ORIG  = 2'd1;
    localparam logic [1:0] SEL_BLEND = 2'd2;

    typedef struct packed {
        logic       load;
        logic [1:0] sel;
    } t_mrg_ctl;

    // c*255/63 == 4c + c/21 for c < 64
    function automatic logic [7:0] widen6(input logic [5:0] c);
        logic [1:0] extra;
        begin
            if (c >= 6'd63) begin
                extra = 2'd3;
            end else if (c >= 6'd42) begin
                extra = 2'd2;
            end else if (c >= 6'd21) begin
                extra = 2'd1;
            end else begin
                extra = 2'd0;
            end
            widen6 = {c, 2'b00} + {6'd0, extra};
        end
    endfunction

endpackage

FILE: rtl/palette_fade_engine.sv
`timescale 1ns / 1ps
// Load words do not stall the input; the engine takes the next word in the following cycle.
// Emit words hold the input through the read and output states when the result is the goal
// or the start color, and through the blend state as well when blended, where the 16-step
// restoring divider in each color lane runs. The next word is taken once the result is loaded.
// Reset (synchronous, active low) stalls the input, clears control and resets the config
// registers to their defaults; palette contents stay undefined until written.
module palette_fade_engine #(
    parameter int PALETTE_ENTRIES = pfe_pkg::PFE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_entry_index,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_frame_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_entry_out,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfe_pkg::*;

    localparam int SLOT_W = $clog2(PALETTE_ENTRIES);
    localparam logic [15:0] RECIP = 16'(65536 / PALETTE_ENTRIES);
    localparam logic [10:0] ENTRIES_W = 11'(PALETTE_ENTRIES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_BLEND = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic [1:0] r_sel;
    logic [1:0] n_sel;

    logic       r_fade_mode;
    logic [5:0] r_tred;
    logic [5:0] r_tgreen;
    logic [5:0] r_tblue;
    logic [7:0] r_steps;
    logic [7:0] r_first;
    logic [7:0] r_last;

    logic [7:0] r_idx;
    logic [7:0] r_frame;

    logic              acc;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;
    logic [23:0]       quot_prod;
    logic [18:0]       quot_back;
    logic [10:0]       rem0;
    logic [10:0]       rem1;
    logic [SLOT_W-1:0] slot;
    logic [23:0]       wdata;
    logic [23:0]       start_rdata;
    logic [23:0]       tgt_rdata;
    logic [23:0]       goal_rgb;
    logic              in_range;
    logic              is_final;
    logic              lane_start;
    logic [2:0]        lane_done;
    logic [7:0]        red_lane;
    logic [7:0]        green_lane;
    logic [7:0]        blue_lane;
    logic              mrg_free;
    t_mrg_ctl          mrg_ctl;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_mode <= 1'b0;
            r_tred      <= '0;
            r_tgreen    <= '0;
            r_tblue     <= '0;
            r_steps     <= 8'd32;
            r_first     <= 8'd0;
            r_last      <= 8'd255;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FADE_MODE:    r_fade_mode <= pwdata[0];
                REG_TARGET_RED:   r_tred      <= pwdata[5:0];
                REG_TARGET_GREEN: r_tgreen    <= pwdata[5:0];
                REG_TARGET_BLUE:  r_tblue     <= pwdata[5:0];
                REG_STEP_COUNT:   r_steps     <= pwdata[7:0];
                REG_FIRST_INDEX:  r_first     <= pwdata[7:0];
                REG_LAST_INDEX:   r_last      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FADE_MODE:    prdata = {31'd0, r_fade_mode};
            REG_TARGET_RED:   prdata = {26'd0, r_tred};
            REG_TARGET_GREEN: prdata = {26'd0, r_tgreen};
            REG_TARGET_BLUE:  prdata = {26'd0, r_tblue};
            REG_STEP_COUNT:   prdata = {24'd0, r_steps};
            REG_FIRST_INDEX:  prdata = {24'd0, r_first};
            REG_LAST_INDEX:   prdata = {24'd0, r_last};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- input side and palette stores ----------------
    assign o_stall = !i_rst_n || (r_state != S_IDLE);
    assign acc     = i_valid && !o_stall;

    // entry_index mod PALETTE_ENTRIES: reciprocal estimate is low by at most one
    assign quot_prod = {16'd0, i_entry_index} * {8'd0, RECIP};
    assign quot_back = {11'd0, quot_prod[23:16]} * {8'd0, ENTRIES_W};
    assign rem0      = 11'({11'd0, i_entry_index} - quot_back);
    assign rem1      = (rem0 >= ENTRIES_W) ? (rem0 - ENTRIES_W) : rem0;
    assign slot      = SLOT_W'(rem1);
    assign wdata     = {i_red_in, i_green_in, i_blue_in};

    pfe_store #(
        .DEPTH (PALETTE_ENTRIES)
    ) u_start (
        .i_clk   (i_clk),
        .i_we    (acc && (i_opcode == OP_LOAD_START)),
        .i_waddr (slot),
        .i_wdata (wdata),
        .i_re    (acc && (i_opcode == OP_EMIT)),
        .i_raddr (slot),
        .o_rdata (start_rdata)
    );

    pfe_store #(
        .DEPTH (PALETTE_ENTRIES)
    ) u_target (
        .i_clk   (i_clk),
        .i_we    (acc && (i_opcode == OP_LOAD_TARGET)),
        .i_waddr (slot),
        .i_wdata (wdata),
        .i_re    (acc && (i_opcode == OP_EMIT)),
        .i_raddr (slot),
        .o_rdata (tgt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (acc && (i_opcode == OP_EMIT)) begin
            r_idx   <= i_entry_index;
            r_frame <= i_frame_number;
        end
    end

    // ---------------- goal and decision ----------------
    assign goal_rgb = r_fade_mode ? tgt_rdata
                                  : {widen6(r_tred), widen6(r_tgreen), widen6(r_tblue)};
    assign is_final = (r_frame >= r_steps);
    assign in_range = (r_idx >= r_first) && (r_idx <= r_last);

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        lane_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc && (i_opcode == OP_EMIT)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (is_final) begin
                    n_sel   = SEL_GOAL;
                    n_state = S_OUT;
                end else if (in_range) begin
                    lane_start = 1'b1;
                    n_state    = S_BLEND;
                end else begin
                    n_sel   = SEL_ORIG;
                    n_state = S_OUT;
                end
            end
            S_BLEND: begin
                if (&lane_done) begin
                    n_sel   = SEL_BLEND;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (mrg_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_GOAL;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    // ---------------- color lanes ----------------
    pfe_lane u_lane_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_orig  (start_rdata[23:16]),
        .i_goal  (goal_rgb[23:16]),
        .i_frame (r_frame),
        .i_steps (r_steps),
        .o_done  (lane_done[0]),
        .o_chan  (red_lane)
    );

    pfe_lane u_lane_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_orig  (start_rdata[15:8]),
        .i_goal  (goal_rgb[15:8]),
        .i_frame (r_frame),
        .i_steps (r_steps),
        .o_done  (lane_done[1]),
        .o_chan  (green_lane)
    );

    pfe_lane u_lane_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_orig  (start_rdata[7:0]),
        .i_goal  (goal_rgb[7:0]),
        .i_frame (r_frame),
        .i_steps (r_steps),
        .o_done  (lane_done[2]),
        .o_chan  (blue_lane)
    );

    // ---------------- merge and output register ----------------
    assign mrg_ctl.load = (r_state == S_OUT);
    assign mrg_ctl.sel  = r_sel;

    pfe_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (mrg_ctl),
        .i_entry      (r_idx),
        .i_orig       (start_rdata),
        .i_goal       (goal_rgb),
        .i_red_lane   (red_lane),
        .i_green_lane (green_lane),
        .i_blue_lane  (blue_lane),
        .o_free       (mrg_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_entry_out  (o_entry_out),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out)
    );

endmodule

FILE: rtl/pfe_store.sv
`timescale 1ns / 1ps
module pfe_store #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [23:0]              i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [23:0]              o_rdata
);
    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pfe_lane.sv
`timescale 1ns / 1ps
module pfe_lane (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_orig,
    input  logic [7:0] i_goal,
    input  logic [7:0] i_frame,
    input  logic [7:0] i_steps,
    output logic       o_done,
    output logic [7:0] o_chan
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(PFE_DIV_STEPS + 1);

    logic signed [8:0] delta;
    logic [7:0]        mag;
    logic [15:0]       prod;
    logic [8:0]        trial;
    logic [8:0]        diff;
    logic              ge;

    logic [15:0]      r_quo;
    logic [7:0]       r_rem;
    logic [7:0]       r_steps;
    logic [7:0]       r_orig;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    assign delta = $signed({1'b0, i_goal}) - $signed({1'b0, i_orig});
    assign mag   = delta[8] ? 8'(-delta) : delta[7:0];
    assign prod  = {8'd0, mag} * {8'd0, i_frame};

    // restoring divide of |delta*frame| by steps, one quotient bit per cycle
    assign trial = {r_rem, r_quo[15]};
    assign ge    = trial >= {1'b0, r_steps};
    assign diff  = trial - {1'b0, r_steps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(PFE_DIV_STEPS);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo   <= prod;
            r_rem   <= '0;
            r_steps <= i_steps;
            r_orig  <= i_orig;
            r_neg   <= delta[8];
        end else if (r_run) begin
            r_quo <= {r_quo[14:0], ge};
            r_rem <= ge ? diff[7:0] : trial[7:0];
        end
    end

    // truncation toward zero: apply the sign to the magnitude quotient
    assign o_chan = r_neg ? (r_orig - r_quo[7:0]) : (r_orig + r_quo[7:0]);
    assign o_done = r_done;

endmodule

FILE: rtl/pfe_merge.sv
`timescale 1ns / 1ps
module pfe_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfe_pkg::t_mrg_ctl i_ctl,
    input  logic [7:0]        i_entry,
    input  logic [23:0]       i_orig,
    input  logic [23:0]       i_goal,
    input  logic [7:0]        i_red_lane,
    input  logic [7:0]        i_green_lane,
    input  logic [7:0]        i_blue_lane,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_entry_out,
    output logic [7:0]        o_red_out,
    output logic [7:0]        o_green_out,
    output logic [7:0]        o_blue_out
);
    import pfe_pkg::*;

    logic [23:0] pick;
    logic        r_valid;
    logic [7:0]  r_entry;
    logic [23:0] r_rgb;

    always_comb begin
        case (i_ctl.sel)
            SEL_GOAL:  pick = i_goal;
            SEL_ORIG:  pick = i_orig;
            SEL_BLEND: pick = {i_red_lane, i_green_lane, i_blue_lane};
            default:   pick = i_orig;
        endcase
    end

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_ctl.load) begin
            r_entry <= i_entry;
            r_rgb   <= pick;
        end
    end

    assign o_valid     = r_valid;
    assign o_entry_out = r_entry;
    assign o_red_out   = r_rgb[23:16];
    assign o_green_out = r_rgb[15:8];
    assign o_blue_out  = r_rgb[7:0];

endmodule

FILE: rtl/pfe_checker.sv
`timescale 1ns / 1ps
`include "palette_fade_engine_assert.svh"
module pfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_opcode,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_entry_out,
    input logic [7:0] o_red_out,
    input logic [7:0] o_green_out,
    input logic [7:0] o_blue_out
);
    import pfe_pkg::*;

    `PFE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_entry_out) && $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out),
        "stalled output word changed")

    `PFE_ASSERT_NEXT(a_emit_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_opcode == OP_EMIT),
        o_stall, "engine not busy after taking an emit word")

    `PFE_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n,
        i_valid && !o_stall && (i_opcode != OP_EMIT) && !o_valid,
        !o_valid, "load word produced an output word")

    `PFE_ASSERT_NOW(a_rise_from_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_stall),
        "output word appeared without an emit in flight")

endmodule

bind palette_fade_engine pfe_checker u_pfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_opcode    (i_opcode),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_entry_out (o_entry_out),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out)
);

FILE: tb/palette_fade_engine_tb.sv
`timescale 1ns / 1ps
module palette_fade_engine_tb;
    import pfe_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 100;

    typedef struct packed {
        logic [7:0] entry;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  reg_sel;
        logic [7:0]  reg_val;
        logic [1:0]  op;
        logic [7:0]  idx;
        logic [23:0] rgb;
        logic [7:0]  frame;
        logic        typed;
        logic [23:0] rgb_exp;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [7:0]  i_entry_index;
    logic [7:0]  i_red_in;
    logic [7:0]  i_green_in;
    logic [7:0]  i_blue_in;
    logic [7:0]  i_frame_number;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_entry_out;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    palette_fade_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_frame_number (i_frame_number),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_entry_out    (o_entry_out),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // shadow of the engine's registers and palettes
    logic        mode_q;
    logic [5:0]  tgt_r;
    logic [5:0]  tgt_g;
    logic [5:0]  tgt_b;
    logic [7:0]  steps;
    logic [7:0]  first_q;
    logic [7:0]  last_q;
    logic [23:0] start_pal [256];
    logic [23:0] target_pal [256];
    bit          start_set [256];
    bit          target_set [256];

    t_color      colours_due [$];
    int          mismatches = 0;
    bit          quiet = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("palette_fade_engine regression: fail");
        $finish;
    end

    function automatic logic [7:0] widen(input logic [5:0] c);
        return 8'((int'(c) * 255) / 63);
    endfunction

    // int division truncates toward zero, as the fade math requires
    function automatic logic [7:0] lerp(input logic [7:0] orig, input logic [7:0] goal,
                                        input logic [7:0] frame, input logic [7:0] n);
        int delta;
        delta = int'(goal) - int'(orig);
        return 8'(int'(orig) + (delta * int'(frame)) / int'(n));
    endfunction

    function automatic t_color fade_colour(input logic [7:0] idx, input logic [7:0] frame);
        logic [23:0] orig;
        logic [23:0] goal;
        logic [23:0] res;
        orig = start_pal[idx];
        goal = mode_q ? target_pal[idx] : {widen(tgt_r), widen(tgt_g), widen(tgt_b)};
        if (frame >= steps) begin
            res = goal;
        end else if (idx >= first_q && idx <= last_q) begin
            res = {lerp(orig[23:16], goal[23:16], frame, steps),
                   lerp(orig[15:8], goal[15:8], frame, steps),
                   lerp(orig[7:0], goal[7:0], frame, steps)};
        end else begin
            res = orig;
        end
        return {idx, res};
    endfunction

    function automatic bit can_read(input logic [7:0] idx);
        return start_set[idx] && (!mode_q || target_set[idx]);
    endfunction

    function automatic t_stim_row word_row(input logic [1:0] op, input logic [7:0] idx,
                                           input logic [23:0] rgb, input logic [7:0] frame,
                                           input logic typed, input logic [23:0] rgb_exp);
        t_stim_row r;
        r = '0;
        r.kind = ROW_WORD;
        r.op = op;
        r.idx = idx;
        r.rgb = rgb;
        r.frame = frame;
        r.typed = typed;
        r.rgb_exp = rgb_exp;
        return r;
    endfunction

    function automatic t_stim_row reg_row(input logic [2:0] sel, input logic [7:0] value);
        t_stim_row r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_sel = sel;
        r.reg_val = value;
        return r;
    endfunction

    task automatic push_word(input logic [1:0] op, input logic [7:0] idx,
                             input logic [23:0] rgb, input logic [7:0] frame,
                             input logic typed, input logic [23:0] rgb_exp);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_entry_index  <= idx;
        i_red_in       <= rgb[23:16];
        i_green_in     <= rgb[15:8];
        i_blue_in      <= rgb[7:0];
        i_frame_number <= frame;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        case (op)
            OP_LOAD_START: begin
                start_pal[idx] = rgb;
                start_set[idx] = 1'b1;
            end
            OP_LOAD_TARGET: begin
                target_pal[idx] = rgb;
                target_set[idx] = 1'b1;
            end
            OP_EMIT: begin
                if (typed) begin
                    colours_due.push_back({idx, rgb_exp});
                end else begin
                    colours_due.push_back(fade_colour(idx, frame));
                end
            end
            default: ;
        endcase
    endtask

    // hold the sender until every due color is out and trailing loads have retired
    task automatic settle();
        i_valid <= 1'b0;
        while (colours_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] sel, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_FADE_MODE:    mode_q  = value[0];
            REG_TARGET_RED:   tgt_r   = value[5:0];
            REG_TARGET_GREEN: tgt_g   = value[5:0];
            REG_TARGET_BLUE:  tgt_b   = value[5:0];
            REG_STEP_COUNT:   steps   = value;
            REG_FIRST_INDEX:  first_q = value;
            REG_LAST_INDEX:   last_q  = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_color want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (colours_due.size() == 0) begin
                $error("unexpected result word for entry %0d", o_entry_out);
                mismatches++;
            end else begin
                want = colours_due.pop_front();
                check_field("entry_out", want.entry, o_entry_out);
                check_field("red_out", want.red, o_red_out);
                check_field("green_out", want.green, o_green_out);
                check_field("blue_out", want.blue, o_blue_out);
            end
        end
    end

    initial begin
        t_stim_row   script [$];
        logic [7:0]  idx;
        logic [7:0]  frame;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [1:0]  op;
        int          words;
        int          pick;
        int          stride;
        int          f;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_opcode       <= OP_LOAD_START;
        i_entry_index  <= '0;
        i_red_in       <= '0;
        i_green_in     <= '0;
        i_blue_in      <= '0;
        i_frame_number <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        mode_q  = 1'b0;
        tgt_r   = '0;
        tgt_g   = '0;
        tgt_b   = '0;
        steps   = 8'd32;
        first_q = 8'd0;
        last_q  = 8'd255;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, starting from the reset register values
        script.push_back(word_row(OP_LOAD_START, 8'd0, 24'hffffff, 8'd0, 1'b0, '0));
        script.push_back(word_row(OP_LOAD_START, 8'd255, 24'h000000, 8'd0, 1'b0, '0));
        script.push_back(word_row(OP_LOAD_TARGET, 8'd0, 24'h000000, 8'd0, 1'b0, '0));
        script.push_back(word_row(OP_LOAD_TARGET, 8'd255, 24'hffffff, 8'd0, 1'b0, '0));
        script.push_back(word_row(OP_LOAD_START, 8'd128, 24'h8040c0, 8'd0, 1'b0, '0));
        script.push_back(word_row(OP_LOAD_TARGET, 8'd128, 24'h10f0c0, 8'd0, 1'b0, '0));
        script.push_back(word_row(OP_EMIT, 8'd0, '0, 8'd0, 1'b1, 24'hffffff));
        // -127.5 truncates toward zero
        script.push_back(word_row(OP_EMIT, 8'd0, '0, 8'd16, 1'b1, 24'h808080));
        script.push_back(word_row(OP_EMIT, 8'd0, '0, 8'd32, 1'b1, 24'h000000));
        script.push_back(word_row(OP_EMIT, 8'd255, '0, 8'd255, 1'b1, 24'h000000));
        script.push_back(word_row(OP_EMIT, 8'd128, '0, 8'd7, 1'b0, '0));
        script.push_back(word_row(OP_UNUSED, 8'd128, 24'h55aa55, 8'd9, 1'b0, '0));
        script.push_back(reg_row(REG_TARGET_RED, 8'd63));
        script.push_back(reg_row(REG_TARGET_GREEN, 8'd63));
        script.push_back(reg_row(REG_TARGET_BLUE, 8'd63));
        script.push_back(word_row(OP_EMIT, 8'd255, '0, 8'd31, 1'b1, 24'hf7f7f7));
        script.push_back(word_row(OP_EMIT, 8'd0, '0, 8'd40, 1'b1, 24'hffffff));
        script.push_back(reg_row(REG_FADE_MODE, 8'd1));
        script.push_back(word_row(OP_EMIT, 8'd128, '0, 8'd200, 1'b1, 24'h10f0c0));
        script.push_back(word_row(OP_EMIT, 8'd0, '0, 8'd16, 1'b1, 24'h808080));
        // zero step count: always the goal colour
        script.push_back(reg_row(REG_STEP_COUNT, 8'd0));
        script.push_back(word_row(OP_EMIT, 8'd255, '0, 8'd0, 1'b1, 24'hffffff));
        // empty range keeps the start colour
        script.push_back(reg_row(REG_STEP_COUNT, 8'd255));
        script.push_back(reg_row(REG_FIRST_INDEX, 8'd200));
        script.push_back(reg_row(REG_LAST_INDEX, 8'd100));
        script.push_back(word_row(OP_EMIT, 8'd128, '0, 8'd254, 1'b1, 24'h8040c0));
        script.push_back(reg_row(REG_FIRST_INDEX, 8'd255));
        script.push_back(reg_row(REG_LAST_INDEX, 8'd255));
        script.push_back(word_row(OP_EMIT, 8'd255, '0, 8'd254, 1'b1, 24'hfefefe));
        script.push_back(word_row(OP_EMIT, 8'd0, '0, 8'd254, 1'b1, 24'hffffff));

        foreach (script[k]) begin
            if (script[k].kind == ROW_REG) begin
                settle();
                reg_write(script[k].reg_sel, script[k].reg_val);
            end else begin
                push_word(script[k].op, script[k].idx, script[k].rgb, script[k].frame,
                          script[k].typed, script[k].rgb_exp);
            end
        end

        // random part: one register setting per phase, extremes first
        for (int p = 0; p < PHASES; p++) begin
            settle();
            quiet = (p == PHASES - 1);
            reg_write(REG_FADE_MODE, (p < 2) ? 8'(p) : 8'($urandom_range(0, 1)));
            case (p)
                2: begin
                    reg_write(REG_TARGET_RED, 8'd0);
                    reg_write(REG_TARGET_GREEN, 8'd0);
                    reg_write(REG_TARGET_BLUE, 8'd0);
                end
                3: begin
                    reg_write(REG_TARGET_RED, 8'd63);
                    reg_write(REG_TARGET_GREEN, 8'd63);
                    reg_write(REG_TARGET_BLUE, 8'd63);
                end
                default: begin
                    reg_write(REG_TARGET_RED, 8'($urandom_range(0, 63)));
                    reg_write(REG_TARGET_GREEN, 8'($urandom_range(0, 63)));
                    reg_write(REG_TARGET_BLUE, 8'($urandom_range(0, 63)));
                end
            endcase
            case (p)
                0: reg_write(REG_STEP_COUNT, 8'd32);
                1: reg_write(REG_STEP_COUNT, 8'd1);
                2: reg_write(REG_STEP_COUNT, 8'd255);
                3: reg_write(REG_STEP_COUNT, 8'd0);
                4: reg_write(REG_STEP_COUNT, 8'd2);
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        reg_write(REG_STEP_COUNT, 8'($urandom_range(0, 255)));
                    end else begin
                        reg_write(REG_STEP_COUNT, 8'($urandom_range(1, 20)));
                    end
                end
            endcase
            case (p % 4)
                0: begin
                    lo = 8'd0;
                    hi = 8'd255;
                end
                1: begin
                    lo = 8'($urandom_range(0, 200));
                    hi = 8'($urandom_range(lo, 255));
                end
                2: begin
                    lo = 8'($urandom_range(1, 255));
                    hi = 8'($urandom_range(0, lo - 1));
                end
                default: begin
                    lo = 8'($urandom_range(0, 255));
                    hi = lo;
                end
            endcase
            reg_write(REG_FIRST_INDEX, lo);
            reg_write(REG_LAST_INDEX, hi);

            words = 0;
            while (words < WORDS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                idx = 8'($urandom_range(0, 255));
                if (pick >= 45 && pick < 95 && first_q <= last_q && $urandom_range(0, 1)) begin
                    idx = 8'($urandom_range(first_q, last_q));
                end
                // an emit never reads an entry that was not loaded
                if (pick >= 45 && pick < 95) begin
                    for (int t = 0; t < 16 && !can_read(idx); t++) begin
                        idx = 8'($urandom_range(0, 255));
                    end
                    if (!can_read(idx)) begin
                        pick = start_set[idx] ? 30 : 0;
                    end
                end
                if (pick < 30) begin
                    op = OP_LOAD_START;
                end else if (pick < 45) begin
                    op = OP_LOAD_TARGET;
                end else if (pick < 95) begin
                    op = OP_EMIT;
                end else begin
                    op = OP_UNUSED;
                end

                if (op == OP_EMIT && $urandom_range(0, 9) == 0) begin
                    // a whole fade of one entry, stepping the frame by steps/6 + 1 and ending on steps
                    stride = steps / 6 + 1;
                    for (f = 0; f <= steps; f += stride) begin
                        push_word(OP_EMIT, idx, 24'($urandom), 8'(f), 1'b0, '0);
                        words++;
                    end
                    push_word(OP_EMIT, idx, 24'($urandom), steps, 1'b0, '0);
                    words++;
                end else begin
                    if (steps != 0 && $urandom_range(0, 3) != 0) begin
                        frame = 8'($urandom_range(0, steps - 1));
                    end else begin
                        frame = 8'($urandom_range(0, 255));
                    end
                    push_word(op, idx, 24'($urandom), frame, 1'b0, '0);
                    if (op != OP_UNUSED) begin
                        words++;
                    end
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("palette_fade_engine regression: pass");
        end else begin
            $display("palette_fade_engine regression: fail");
        end
        $finish;
    end

endmodule
